FILE: hw/rtl/gbs_pkg.sv
`timescale 1ns / 1ps
package gbs_pkg;

    localparam int COORD_BITS = 12;
    localparam int CONF_BITS  = 16;
    localparam int THR_BITS   = 17;
    localparam logic [THR_BITS-1:0] THR_RESET = 17'd29491;

    // widths inside the overlap unit
    localparam int EDGE_W = COORD_BITS + 1;
    localparam int AREA_W = 2 * COORD_BITS;
    localparam int INTER_W = 2 * EDGE_W;
    localparam int UNI_W = 2 * COORD_BITS + 1;
    localparam int UNI_LO_W = UNI_W / 2;
    localparam int UNI_HI_W = UNI_W - UNI_LO_W;
    localparam int CMP_W = THR_BITS + UNI_W;

    typedef struct packed {
        logic                  has_box;
        logic [COORD_BITS-1:0] box_x;
        logic [COORD_BITS-1:0] box_y;
        logic [COORD_BITS-1:0] box_w;
        logic [COORD_BITS-1:0] box_h;
        logic [CONF_BITS-1:0]  box_conf;
        logic                  set_last;
    } in_word_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] kept_x;
        logic [COORD_BITS-1:0] kept_y;
        logic [COORD_BITS-1:0] kept_w;
        logic [COORD_BITS-1:0] kept_h;
        logic [CONF_BITS-1:0]  kept_conf;
        logic                  overflowed;
        logic                  kept_last;
    } out_word_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] w;
        logic [COORD_BITS-1:0] h;
        logic [CONF_BITS-1:0]  conf;
    } box_t;

    typedef struct packed {
        box_t box;
        logic sup;
    } cell_t;

    typedef struct packed {
        logic insert;
        logic shift;
        logic rotate;
    } cell_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_CMP,
        ST_FLUSH
    } state_t;

endpackage

FILE: hw/rtl/gbs_cell.sv
`timescale 1ns / 1ps
module gbs_cell (
    input  logic              clk,
    input  gbs_pkg::cell_ctl_t ctl,
    input  logic              valid,
    input  logic              tail,
    input  logic              left_keep,
    input  gbs_pkg::box_t     new_box,
    input  gbs_pkg::cell_t    left,
    input  gbs_pkg::cell_t    right,
    input  gbs_pkg::cell_t    head,
    output logic              keep,
    output gbs_pkg::cell_t    data
);

    gbs_pkg::cell_t data_reg;
    gbs_pkg::cell_t data_next;

    // sorted descending, so the cells that keep their box form a prefix
    assign keep = valid && (data_reg.box.conf >= new_box.conf);
    assign data = data_reg;

    always_comb
    begin
        data_next = data_reg;
        priority if (ctl.insert)
        begin
            if (!keep)
            begin
                if (left_keep)
                begin
                    data_next.box = new_box;
                    data_next.sup = 1'b0;
                end
                else
                begin
                    data_next = left;
                end
            end
        end
        else if (ctl.shift)
        begin
            data_next = right;
        end
        else if (ctl.rotate)
        begin
            data_next = tail ? head : right;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

FILE: hw/rtl/gbs_iou.sv
`timescale 1ns / 1ps
module gbs_iou (
    input  logic                           clk,
    input  gbs_pkg::box_t                  a,
    input  gbs_pkg::box_t                  b,
    input  logic [gbs_pkg::THR_BITS-1:0]   thr,
    output logic                           hit
);

    localparam int EW = gbs_pkg::EDGE_W;

    logic [EW-1:0] ax2, bx2, ay2, by2, ix1, iy1, ix2, iy2, iw, ih;

    logic [gbs_pkg::INTER_W-1:0] inter_reg, inter2_reg, inter3_reg;
    logic [gbs_pkg::AREA_W-1:0]  area_a_reg, area_b_reg;
    logic [gbs_pkg::UNI_W-1:0]   uni_reg;
    logic [gbs_pkg::THR_BITS+gbs_pkg::UNI_LO_W-1:0] p_lo_reg;
    logic [gbs_pkg::THR_BITS+gbs_pkg::UNI_HI_W-1:0] p_hi_reg;
    logic                        uni_zero_reg;
    logic [gbs_pkg::CMP_W-1:0]   lhs, rhs;

    always_comb
    begin
        ax2 = EW'(a.x) + EW'(a.w);
        bx2 = EW'(b.x) + EW'(b.w);
        ay2 = EW'(a.y) + EW'(a.h);
        by2 = EW'(b.y) + EW'(b.h);
        ix1 = (a.x > b.x) ? EW'(a.x) : EW'(b.x);
        iy1 = (a.y > b.y) ? EW'(a.y) : EW'(b.y);
        ix2 = (ax2 < bx2) ? ax2 : bx2;
        iy2 = (ay2 < by2) ? ay2 : by2;
        iw = (ix2 > ix1) ? ix2 - ix1 : '0;
        ih = (iy2 > iy1) ? iy2 - iy1 : '0;
    end

    always_ff @(posedge clk)
    begin
        // products
        inter_reg  <= iw * ih;
        area_a_reg <= a.w * a.h;
        area_b_reg <= b.w * b.h;
        // union
        uni_reg    <= gbs_pkg::UNI_W'(area_a_reg) + gbs_pkg::UNI_W'(area_b_reg)
                      - gbs_pkg::UNI_W'(inter_reg);
        inter2_reg <= inter_reg;
        // threshold times union, in two halves
        p_lo_reg <= thr * uni_reg[gbs_pkg::UNI_LO_W-1:0];
        p_hi_reg <= thr * uni_reg[gbs_pkg::UNI_W-1:gbs_pkg::UNI_LO_W];
        uni_zero_reg <= (uni_reg == '0);
        inter3_reg <= inter2_reg;
    end

    always_comb
    begin
        lhs = gbs_pkg::CMP_W'(inter3_reg) << 16;
        rhs = (gbs_pkg::CMP_W'(p_hi_reg) << gbs_pkg::UNI_LO_W) + gbs_pkg::CMP_W'(p_lo_reg);
        hit = !uni_zero_reg && (lhs > rhs);
    end

endmodule

FILE: hw/rtl/greedy_box_suppression.sv
`timescale 1ns / 1ps
// Greedy box suppression. Boxes are taken one word per cycle and inserted in a chain of
// MAX_BOXES cells kept sorted by descending confidence (ties keep arrival order); boxes past
// capacity are dropped and flag the set. The word marked set_last starts suppression and
// input stalls until the set is done: the head box is popped, and dropped if suppressed;
// each kept box is checked against every remaining box by rotating the chain past one
// shared overlap unit. Kept boxes leave in order, the final one marked kept_last.
module greedy_box_suppression #(
    parameter int MAX_BOXES = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  gbs_pkg::in_word_t             in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output gbs_pkg::out_word_t            out_data,
    input  logic                          cfg_write,
    input  logic [gbs_pkg::THR_BITS-1:0]  cfg_data
);

    localparam int CW = $clog2(MAX_BOXES + 1);

    gbs_pkg::state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] rot_reg, rot_next;
    logic [1:0]    step_reg, step_next;
    logic          ovf_reg, ovf_next;
    logic          pend_valid_reg, pend_valid_next;
    gbs_pkg::box_t pend_reg, pend_next;
    logic [gbs_pkg::THR_BITS-1:0] thr_reg;
    logic          out_valid_reg, out_valid_next;
    gbs_pkg::out_word_t out_reg, out_next;

    gbs_pkg::cell_ctl_t ctl;
    gbs_pkg::cell_t     cells [MAX_BOXES];
    gbs_pkg::cell_t     head_upd;
    logic [MAX_BOXES-1:0] keep;
    logic          hit, accept, out_free, load_out, out_last;

    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        head_upd = cells[0];
        head_upd.sup = cells[0].sup | hit;
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_BOXES; gi++)
        begin : g_cell
            gbs_cell u_cell (
                .clk      (clk),
                .ctl      (ctl),
                .valid    (CW'(gi) < cnt_reg),
                .tail     (CW'(gi) == cnt_reg - CW'(1)),
                .left_keep((gi == 0) ? 1'b1 : keep[(gi == 0) ? 0 : gi - 1]),
                .new_box  ({in_data.box_x, in_data.box_y, in_data.box_w, in_data.box_h,
                            in_data.box_conf}),
                .left     (cells[(gi == 0) ? 0 : gi - 1]),
                .right    (cells[(gi == MAX_BOXES - 1) ? gi : gi + 1]),
                .head     (head_upd),
                .keep     (keep[gi]),
                .data     (cells[gi])
            );
        end
    endgenerate

    gbs_iou u_iou (
        .clk(clk),
        .a  (pend_reg),
        .b  (cells[0].box),
        .thr(thr_reg),
        .hit(hit)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gbs_pkg::ST_IDLE:
            begin
                if (accept && in_data.set_last)
                    state_next = gbs_pkg::ST_POP;
            end
            gbs_pkg::ST_POP:
            begin
                if (cnt_reg == '0)
                    state_next = pend_valid_reg ? gbs_pkg::ST_FLUSH : gbs_pkg::ST_IDLE;
                else if (!cells[0].sup && (!pend_valid_reg || out_free)
                         && cnt_reg != CW'(1))
                    state_next = gbs_pkg::ST_CMP;
            end
            gbs_pkg::ST_CMP:
            begin
                if (step_reg == 2'd3 && rot_reg == CW'(1))
                    state_next = gbs_pkg::ST_POP;
            end
            gbs_pkg::ST_FLUSH:
            begin
                if (out_free)
                    state_next = gbs_pkg::ST_IDLE;
            end
            default: state_next = gbs_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath control
    always_comb
    begin
        in_stall = 1'b1;
        ctl = '0;
        cnt_next = cnt_reg;
        rot_next = rot_reg;
        step_next = step_reg;
        ovf_next = ovf_reg;
        pend_valid_next = pend_valid_reg;
        pend_next = pend_reg;
        load_out = 1'b0;
        out_last = 1'b0;
        unique case (state_reg)
            gbs_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (accept && in_data.has_box)
                begin
                    if (cnt_reg < CW'(MAX_BOXES))
                    begin
                        ctl.insert = 1'b1;
                        cnt_next = cnt_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end
            gbs_pkg::ST_POP:
            begin
                if (cnt_reg == '0)
                begin
                    if (!pend_valid_reg)
                        ovf_next = 1'b0;
                end
                else if (cells[0].sup)
                begin
                    ctl.shift = 1'b1;
                    cnt_next = cnt_reg - CW'(1);
                end
                else if (!pend_valid_reg || out_free)
                begin
                    load_out = pend_valid_reg;
                    pend_next = cells[0].box;
                    pend_valid_next = 1'b1;
                    ctl.shift = 1'b1;
                    cnt_next = cnt_reg - CW'(1);
                    rot_next = cnt_reg - CW'(1);
                    step_next = 2'd0;
                end
            end
            gbs_pkg::ST_CMP:
            begin
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    ctl.rotate = 1'b1;
                    rot_next = rot_reg - CW'(1);
                end
            end
            gbs_pkg::ST_FLUSH:
            begin
                if (out_free)
                begin
                    load_out = 1'b1;
                    out_last = 1'b1;
                    pend_valid_next = 1'b0;
                    ovf_next = 1'b0;
                end
            end
            default: ;
        endcase

        out_valid_next = out_valid_reg && out_stall;
        out_next = out_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_next = {pend_reg.x, pend_reg.y, pend_reg.w, pend_reg.h, pend_reg.conf,
                        ovf_reg, out_last};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gbs_pkg::ST_IDLE;
            cnt_reg <= '0;
            rot_reg <= '0;
            step_reg <= '0;
            ovf_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            thr_reg <= gbs_pkg::THR_RESET;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            rot_reg <= rot_next;
            step_reg <= step_next;
            ovf_reg <= ovf_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
                thr_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg <= out_next;
    end

endmodule

FILE: tb/sv/greedy_box_suppression_test.sv
`timescale 1ns / 1ps
module greedy_box_suppression_test;

    localparam int CAPACITY = 64;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE_CYCLES = 60;

    typedef struct {
        gbs_pkg::in_word_t  word;
        bit                 typed;
        gbs_pkg::out_word_t kept;
    } stim_row_t;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    gbs_pkg::in_word_t            in_data;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    gbs_pkg::out_word_t           out_data;
    logic                         cfg_write;
    logic [gbs_pkg::THR_BITS-1:0] cfg_data;

    greedy_box_suppression u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic [gbs_pkg::THR_BITS-1:0] iou_thr;
    gbs_pkg::box_t                boxes[CAPACITY];
    int                           box_num;
    bit                           dropped;
    gbs_pkg::out_word_t           kept_q[$];

    int  errors = 0;
    int  cycles = 0;
    int  send_idle_pct;
    int  recv_idle_pct;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic bit overlaps(gbs_pkg::box_t a, gbs_pkg::box_t b);
        longint unsigned ix1, iy1, ix2, iy2, iw, ih, inter, uni, ax2, ay2, bx2, by2;
        ax2 = longint'(a.x) + a.w;
        ay2 = longint'(a.y) + a.h;
        bx2 = longint'(b.x) + b.w;
        by2 = longint'(b.y) + b.h;
        ix1 = (a.x > b.x) ? a.x : b.x;
        iy1 = (a.y > b.y) ? a.y : b.y;
        ix2 = (ax2 < bx2) ? ax2 : bx2;
        iy2 = (ay2 < by2) ? ay2 : by2;
        iw = (ix2 > ix1) ? ix2 - ix1 : 0;
        ih = (iy2 > iy1) ? iy2 - iy1 : 0;
        inter = iw * ih;
        uni = longint'(a.w) * a.h + longint'(b.w) * b.h - inter;
        if (uni == 0)
            return 1'b0;
        return (inter * 65536) > (longint'(iou_thr) * uni);
    endfunction

    // stores a box and, on the closing word, queues every kept box of the set
    task automatic suppress_set(gbs_pkg::in_word_t w);
        int   order[CAPACITY];
        bit   gone[CAPACITY];
        int   i, j, kept;
        gbs_pkg::box_t k;
        gbs_pkg::out_word_t r;
        if (w.has_box)
        begin
            if (box_num < CAPACITY)
            begin
                boxes[box_num] = '{w.box_x, w.box_y, w.box_w, w.box_h, w.box_conf};
                box_num++;
            end
            else
                dropped = 1'b1;
        end
        if (!w.set_last)
            return;
        for (i = 0; i < box_num; i++)
        begin
            j = i;
            while (j > 0 && boxes[order[j-1]].conf < boxes[i].conf)
            begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = i;
            gone[i] = 1'b0;
        end
        kept = 0;
        for (i = 0; i < box_num; i++)
        begin
            if (gone[i])
                continue;
            k = boxes[order[i]];
            r = '{k.x, k.y, k.w, k.h, k.conf, dropped, 1'b0};
            kept_q.insert(kept_q.size(), r);
            kept++;
            for (j = i + 1; j < box_num; j++)
                if (!gone[j] && overlaps(k, boxes[order[j]]))
                    gone[j] = 1'b1;
        end
        if (kept > 0)
            kept_q[$].kept_last = 1'b1;
        box_num = 0;
        dropped = 1'b0;
    endtask

    task automatic send_word(gbs_pkg::in_word_t w);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        suppress_set(w);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (kept_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(logic [gbs_pkg::THR_BITS-1:0] v);
        cfg_write <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        iou_thr = v;
    endtask

    function automatic gbs_pkg::in_word_t random_word();
        return gbs_pkg::in_word_t'(66'({$urandom, $urandom, $urandom}));
    endfunction

    function automatic gbs_pkg::in_word_t make_box(gbs_pkg::box_t base, bit near,
                                                   bit close_set);
        gbs_pkg::in_word_t w;
        int unsigned t;
        w.has_box = 1'b1;
        w.set_last = close_set;
        if (near)
        begin
            t = base.x + $urandom_range(0, 12); w.box_x = 12'((t > 4095) ? 4095 : t);
            t = base.y + $urandom_range(0, 12); w.box_y = 12'((t > 4095) ? 4095 : t);
            t = base.w + $urandom_range(0, 12); w.box_w = 12'((t > 4095) ? 4095 : t);
            t = base.h + $urandom_range(0, 12); w.box_h = 12'((t > 4095) ? 4095 : t);
        end
        else
        begin
            w.box_x = 12'($urandom);
            w.box_y = 12'($urandom);
            w.box_w = 12'($urandom);
            w.box_h = 12'($urandom);
        end
        case ($urandom_range(3))
            0: w.box_conf = 16'($urandom_range(0, 3) * 16'h5555);  // ties likely
            default: w.box_conf = 16'($urandom);
        endcase
        return w;
    endfunction

    task automatic random_sets(int words);
        int   sent, size, i;
        gbs_pkg::box_t base;
        gbs_pkg::in_word_t w;
        sent = 0;
        while (sent < words)
        begin
            size = ($urandom_range(15) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 8);
            base = '{12'($urandom_range(0, 3900)), 12'($urandom_range(0, 3900)),
                     12'($urandom_range(1, 150)), 12'($urandom_range(1, 150)), 16'd0};
            for (i = 0; i < size; i++)
            begin
                if ($urandom_range(9) == 0)
                begin
                    w = random_word();
                    w.has_box = 1'b0;
                    w.set_last = 1'b0;
                    send_word(w);
                end
                w = make_box(base, $urandom_range(3) != 0, i == size - 1);
                if (i == size - 1 && $urandom_range(5) == 0)
                begin
                    // close on a separate empty word
                    w.set_last = 1'b0;
                    send_word(w);
                    w = random_word();
                    w.has_box = 1'b0;
                    w.set_last = 1'b1;
                end
                send_word(w);
                sent++;
            end
        end
    endtask

    // output side: check each accepted word, then pick the next stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (kept_q.size() == 0)
            begin
                $display("%0t: unexpected word expected none actual %p", $time, out_data);
                errors++;
            end
            else
            begin
                if (out_data !== kept_q[0])
                begin
                    $display("%0t: mismatch expected %p actual %p", $time, kept_q[0], out_data);
                    errors++;
                end
                void'(kept_q.pop_front());
            end
        end
        out_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        stim_row_t rows[$];
        logic [gbs_pkg::THR_BITS-1:0] thr_plan[5];
        gbs_pkg::in_word_t w;
        int ph, i;

        box_num = 0;
        dropped = 1'b0;
        iou_thr = gbs_pkg::THR_RESET;
        send_idle_pct = 23;
        recv_idle_pct = 70;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_write = 1'b0;
        cfg_data = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, reset threshold
        rows.insert(rows.size(), '{'{1, 4095, 4095, 4095, 4095, 16'hFFFF, 1}, 1,
                                   '{4095, 4095, 4095, 4095, 16'hFFFF, 0, 1}});
        rows.insert(rows.size(), '{'{1, 0, 0, 0, 0, 0, 1}, 1, '{0, 0, 0, 0, 0, 0, 1}});
        rows.insert(rows.size(), '{'{0, 7, 7, 7, 7, 7, 0}, 0, '0});     // ignored word
        rows.insert(rows.size(), '{'{0, 0, 0, 0, 0, 0, 1}, 0, '0});     // empty set
        rows.insert(rows.size(), '{'{1, 10, 10, 100, 100, 500, 0}, 0, '0});
        rows.insert(rows.size(), '{'{1, 10, 10, 100, 100, 500, 1}, 0, '0});
        rows.insert(rows.size(), '{'{1, 0, 0, 10, 10, 300, 0}, 0, '0});  // equal scores
        rows.insert(rows.size(), '{'{1, 100, 0, 10, 10, 300, 0}, 0, '0});
        rows.insert(rows.size(), '{'{1, 200, 0, 10, 10, 300, 1}, 0, '0});
        rows.insert(rows.size(), '{'{1, 5, 5, 0, 0, 9, 0}, 0, '0});      // zero union pair
        rows.insert(rows.size(), '{'{1, 5, 5, 0, 0, 9, 1}, 0, '0});
        rows.insert(rows.size(), '{'{1, 4000, 4000, 4095, 4095, 1, 0}, 0, '0});
        rows.insert(rows.size(), '{'{0, 0, 0, 0, 0, 0, 1}, 0, '0});
        rows.insert(rows.size(), '{'{1, 0, 0, 100, 100, 100, 0}, 0, '0}); // partial overlaps
        rows.insert(rows.size(), '{'{1, 20, 20, 100, 100, 900, 0}, 0, '0});
        rows.insert(rows.size(), '{'{1, 60, 60, 100, 100, 400, 0}, 0, '0});
        rows.insert(rows.size(), '{'{1, 0, 0, 0, 50, 700, 1}, 0, '0});
        rows.insert(rows.size(), '{'{1, 2730, 1365, 2730, 1365, 16'hAAAA, 0}, 0, '0});
        rows.insert(rows.size(), '{'{1, 1365, 2730, 1365, 2730, 16'h5555, 1}, 0, '0});

        foreach (rows[i])
        begin
            send_word(rows[i].word);
            if (rows[i].typed)
                kept_q[kept_q.size() - 1] = rows[i].kept;
        end

        // store full: the extra boxes are dropped and the set is flagged
        for (i = 0; i < CAPACITY + 2; i++)
        begin
            w = random_word();
            w.has_box = 1'b1;
            w.set_last = (i == CAPACITY + 1);
            send_word(w);
        end

        thr_plan[0] = gbs_pkg::THR_RESET;
        thr_plan[1] = '0;
        thr_plan[2] = 17'd65536;
        thr_plan[3] = 17'h1FFFF;
        thr_plan[4] = 17'($urandom_range(0, 65536));
        for (ph = 0; ph < 5; ph++)
        begin
            if (ph > 0)
            begin
                wait_drained();
                write_threshold(thr_plan[ph]);
            end
            if (ph == 2)
            begin
                send_idle_pct = 70;
                recv_idle_pct = 23;
            end
            else if (ph == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_sets(ph == 0 ? 10 : 35);
        end

        wait_drained();
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
